// ===== src/tsvn_pkg.sv =====
// ----------------------------------------------------------------------------
// tsvn_pkg: shared types and constants of the text stream numberer
// Register codes, character codes, the config bundle and the job word that
// travels from the classifying front end to the expanding back end.
// ----------------------------------------------------------------------------
package tsvn_pkg;

    localparam int NUMBER_FIELD_WIDTH_DEF = 6;
    localparam int COUNT_DIGITS_DEF       = 10;
    localparam int MAX_COUNT_DIGITS       = 16;
    localparam int BCD_W                  = 4 * MAX_COUNT_DIGITS;

    // At most this many output words per input word
    localparam int MAX_RES    = 15;
    localparam int POS_W      = $clog2(MAX_RES);
    // Holds the longest uncapped expansion (16 digits, tab, four tail bytes)
    localparam int LEN_W      = 5;

    localparam int TAIL_N     = 4;
    localparam int TAIL_IW    = $clog2(TAIL_N);
    localparam int TAIL_LEN_W = 3;

    localparam int Q_DEPTH    = 2;

    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int BYTE_W     = 8;

    // 2^32 - 1 as BCD: the count wraps to zero after this value
    localparam logic [39:0] WRAP_BCD = 40'h42_9496_7295;

    typedef enum logic [2:0] {
        REG_NUMBER_LINES     = 3'd0,
        REG_NUMBER_NONBLANK  = 3'd1,
        REG_MARK_LINE_ENDS   = 3'd2,
        REG_SQUEEZE_BLANK    = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        NUM_NONE  = 2'd0,
        NUM_COUNT = 2'd1,
        NUM_PAD   = 2'd2
    } t_num_mode;

    typedef struct packed {
        logic number_lines;
        logic number_nonblank_only;
        logic mark_line_ends;
        logic squeeze_blank;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    typedef struct packed {
        t_num_mode                       num_mode;
        logic [BCD_W-1:0]                bcd;
        logic [TAIL_N-1:0][BYTE_W-1:0]   tail;
        logic [TAIL_LEN_W-1:0]           tail_len;
    } t_job;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

endpackage

// ===== src/tsvn_cfg.sv =====
// ----------------------------------------------------------------------------
// tsvn_cfg: configuration registers
// APB-style register file with six one-bit mode flags at word addresses.
// ----------------------------------------------------------------------------
module tsvn_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsvn_pkg::PADDR_W-1:0]   paddr,
    input  logic [tsvn_pkg::PDATA_W-1:0]   pwdata,
    output logic [tsvn_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output tsvn_pkg::t_cfg                 o_cfg
);

    tsvn_pkg::t_cfg     r_cfg;
    tsvn_pkg::t_reg_idx w_idx;
    logic               w_wr;
    logic               w_bit;

    assign pready = 1'b1;
    assign w_idx  = tsvn_pkg::t_reg_idx'(paddr[tsvn_pkg::PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        unique case (w_idx)
            tsvn_pkg::REG_NUMBER_LINES:     w_bit = r_cfg.number_lines;
            tsvn_pkg::REG_NUMBER_NONBLANK:  w_bit = r_cfg.number_nonblank_only;
            tsvn_pkg::REG_MARK_LINE_ENDS:   w_bit = r_cfg.mark_line_ends;
            tsvn_pkg::REG_SQUEEZE_BLANK:    w_bit = r_cfg.squeeze_blank;
            tsvn_pkg::REG_SHOW_TABS:        w_bit = r_cfg.show_tabs;
            tsvn_pkg::REG_SHOW_NONPRINTING: w_bit = r_cfg.show_nonprinting;
            default:                        w_bit = 1'b0;
        endcase
        prdata = {{(tsvn_pkg::PDATA_W-1){1'b0}}, w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                tsvn_pkg::REG_NUMBER_LINES:     r_cfg.number_lines         <= pwdata[0];
                tsvn_pkg::REG_NUMBER_NONBLANK:  r_cfg.number_nonblank_only <= pwdata[0];
                tsvn_pkg::REG_MARK_LINE_ENDS:   r_cfg.mark_line_ends       <= pwdata[0];
                tsvn_pkg::REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank        <= pwdata[0];
                tsvn_pkg::REG_SHOW_TABS:        r_cfg.show_tabs            <= pwdata[0];
                tsvn_pkg::REG_SHOW_NONPRINTING: r_cfg.show_nonprinting     <= pwdata[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== src/tsvn_front.sv =====
// ----------------------------------------------------------------------------
// tsvn_front: input classifier
// Tracks line start, squeeze mark and the BCD line count; turns each input
// word into a job (number kind, count snapshot, rendered tail bytes).
// ----------------------------------------------------------------------------
module tsvn_front #(
    parameter int COUNT_DIGITS       = tsvn_pkg::COUNT_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsvn_pkg::t_cfg                i_cfg,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tsvn_pkg::BYTE_W-1:0]   i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_q_full,
    output logic                          o_push,
    output tsvn_pkg::t_job                o_job
);

    localparam int  CW      = 4 * COUNT_DIGITS;
    localparam bit  WRAP_EN = (COUNT_DIGITS >= 10);
    localparam logic [CW-1:0] WRAP_AT =
        WRAP_EN ? CW'(tsvn_pkg::WRAP_BCD) : '0;

    logic          r_als;
    logic          r_blank;
    logic [CW-1:0] r_cnt;

    logic          w_acc, w_nl, w_nl_like, w_drop;
    logic          w_als_eff, w_blank_eff, w_blank_nxt;
    logic [CW-1:0] w_cnt_eff, w_cnt_inc;
    logic          w_carry;
    logic [3:0]    w_dig;
    logic [6:0]    w_low;
    logic [1:0]    w_base;
    logic          w_ctrl;
    tsvn_pkg::t_num_mode                              w_mode;
    logic [tsvn_pkg::TAIL_N-1:0][tsvn_pkg::BYTE_W-1:0] w_tail;
    logic [tsvn_pkg::TAIL_LEN_W-1:0]                  w_tlen;

    assign o_s_tready = !i_q_full;
    assign w_acc      = i_s_tvalid && !i_q_full;
    assign w_nl       = (i_s_tdata == tsvn_pkg::CH_NL);
    // A high newline shown as M-^J still ends the line
    assign w_nl_like  = w_nl ||
        (i_cfg.show_nonprinting && i_s_tdata == {1'b1, tsvn_pkg::CH_NL[6:0]});

    // First word of a file restarts the line state before it is classified
    assign w_als_eff   = i_s_tuser || r_als;
    assign w_blank_eff = !i_s_tuser && r_blank;
    assign w_cnt_eff   = i_s_tuser ? '0 : r_cnt;

    // BCD increment, wrapping after 2^32 - 1 or at the digit limit
    always_comb begin
        w_carry   = 1'b1;
        w_cnt_inc = w_cnt_eff;
        w_dig     = '0;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            w_dig = w_cnt_eff[4*i +: 4];
            if (w_carry) begin
                w_cnt_inc[4*i +: 4] = (w_dig == 4'd9) ? 4'd0 : w_dig + 4'd1;
            end
            w_carry = w_carry && (w_dig == 4'd9);
        end
        if (WRAP_EN && w_cnt_eff == WRAP_AT) begin
            w_cnt_inc = '0;
        end
    end

    always_comb begin
        w_drop      = w_als_eff && i_cfg.squeeze_blank && w_nl && w_blank_eff;
        w_blank_nxt = w_blank_eff;
        if (w_als_eff && i_cfg.squeeze_blank) begin
            w_blank_nxt = w_nl;
        end
        w_mode = tsvn_pkg::NUM_NONE;
        if (w_als_eff && i_cfg.number_lines) begin
            if (!i_cfg.number_nonblank_only || !w_nl) begin
                w_mode = tsvn_pkg::NUM_COUNT;
            end else if (i_cfg.mark_line_ends) begin
                w_mode = tsvn_pkg::NUM_PAD;
            end
        end
    end

    // Render the byte itself
    always_comb begin
        w_tail    = '0;
        w_tail[0] = i_s_tdata;
        w_tlen    = 3'd1;
        w_low     = i_s_tdata[6:0];
        w_base    = i_s_tdata[7] ? 2'd2 : 2'd0;
        w_ctrl    = (w_low < 7'h20) || (w_low == tsvn_pkg::CH_DEL[6:0]);
        if (w_nl) begin
            if (i_cfg.mark_line_ends) begin
                w_tail[0] = tsvn_pkg::CH_DOLLAR;
                w_tail[1] = tsvn_pkg::CH_NL;
                w_tlen    = 3'd2;
            end
        end else if (i_s_tdata == tsvn_pkg::CH_TAB) begin
            if (i_cfg.show_tabs) begin
                w_tail[0] = tsvn_pkg::CH_CARET;
                w_tail[1] = tsvn_pkg::CH_I;
                w_tlen    = 3'd2;
            end
        end else if (i_cfg.show_nonprinting) begin
            if (i_s_tdata[7]) begin
                w_tail[0] = tsvn_pkg::CH_M;
                w_tail[1] = tsvn_pkg::CH_DASH;
            end
            if (w_ctrl) begin
                w_tail[w_base]         = tsvn_pkg::CH_CARET;
                w_tail[w_base + 2'd1]  = (w_low == tsvn_pkg::CH_DEL[6:0]) ?
                                         tsvn_pkg::CH_QMARK : {2'b01, w_low[5:0]};
                w_tlen                 = {1'b0, w_base} + 3'd2;
            end else begin
                w_tail[w_base] = {1'b0, w_low};
                w_tlen         = {1'b0, w_base} + 3'd1;
            end
        end
    end

    assign o_push         = w_acc && !w_drop;
    assign o_job.num_mode = w_mode;
    assign o_job.bcd      = tsvn_pkg::BCD_W'(w_cnt_inc);
    assign o_job.tail     = w_tail;
    assign o_job.tail_len = w_tlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_als   <= 1'b1;
            r_blank <= 1'b0;
            r_cnt   <= '0;
        end else if (w_acc) begin
            r_blank <= w_blank_nxt;
            // A squeezed newline is not counted
            r_cnt   <= (!w_drop && w_mode == tsvn_pkg::NUM_COUNT) ? w_cnt_inc : w_cnt_eff;
            // A squeezed newline leaves the block at line start
            r_als   <= w_drop ? 1'b1 : w_nl_like;
        end
    end

endmodule

// ===== src/tsvn_queue.sv =====
// ----------------------------------------------------------------------------
// tsvn_queue: job queue
// Short FIFO of jobs between the classifier and the expander.
// ----------------------------------------------------------------------------
module tsvn_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tsvn_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tsvn_pkg::t_job  o_job
);

    localparam int DEPTH = tsvn_pkg::Q_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsvn_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/tsvn_back.sv =====
// ----------------------------------------------------------------------------
// tsvn_back: output expander
// Walks the head job one word per cycle unless m_tready stalls it: padding,
// digits, tab, then rendered tail bytes; drives the registered output stream.
// ----------------------------------------------------------------------------
module tsvn_back #(
    parameter int NUMBER_FIELD_WIDTH = tsvn_pkg::NUMBER_FIELD_WIDTH_DEF,
    parameter int COUNT_DIGITS       = tsvn_pkg::COUNT_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tsvn_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tsvn_pkg::BYTE_W-1:0]   o_m_tdata,
    output logic                          o_m_tlast
);

    localparam int LW     = tsvn_pkg::LEN_W;
    localparam int SIG_W  = $clog2(COUNT_DIGITS + 1);
    localparam int DIG_IW = $clog2(COUNT_DIGITS);
    localparam logic [LW-1:0] FW = LW'(NUMBER_FIELD_WIDTH);

    logic [tsvn_pkg::POS_W-1:0]  r_pos;
    logic                        r_valid;
    logic [tsvn_pkg::BYTE_W-1:0] r_byte;
    logic                        r_last;

    logic [3:0]        w_digits [COUNT_DIGITS];
    logic [SIG_W-1:0]  w_sig;
    logic [LW-1:0]     w_sig5, w_pad, w_nsig, w_lnum, w_total, w_last_pos, w_pos5;
    logic [LW-1:0]     w_didx_full, w_tidx_full;
    logic [DIG_IW-1:0] w_didx;
    logic [tsvn_pkg::BYTE_W-1:0] w_byte;
    logic              w_is_last, w_step;

    // Significant digits: highest nonzero digit, at least one
    always_comb begin
        w_sig = SIG_W'(1);
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            w_digits[i] = i_job.bcd[4*i +: 4];
            if (w_digits[i] != 4'd0) begin
                w_sig = SIG_W'(i + 1);
            end
        end
        w_sig5 = LW'(w_sig);
    end

    always_comb begin
        unique case (i_job.num_mode)
            tsvn_pkg::NUM_COUNT: begin
                w_pad  = (FW > w_sig5) ? FW - w_sig5 : '0;
                w_nsig = w_sig5;
            end
            tsvn_pkg::NUM_PAD: begin
                w_pad  = FW;
                w_nsig = '0;
            end
            default: begin
                w_pad  = '0;
                w_nsig = '0;
            end
        endcase
        w_lnum = (i_job.num_mode == tsvn_pkg::NUM_NONE) ? '0 : w_pad + w_nsig + LW'(1);
        w_total    = w_lnum + LW'(i_job.tail_len);
        // Drop whatever falls past the result limit
        w_last_pos = (w_total > LW'(tsvn_pkg::MAX_RES)) ?
                     LW'(tsvn_pkg::MAX_RES - 1) : w_total - LW'(1);
        w_pos5      = LW'(r_pos);
        w_didx_full = w_pad + w_nsig - LW'(1) - w_pos5;
        w_didx      = w_didx_full[DIG_IW-1:0];
        w_tidx_full = w_pos5 - w_lnum;
        if (w_pos5 < w_lnum) begin
            if (w_pos5 < w_pad) begin
                w_byte = tsvn_pkg::CH_SPACE;
            end else if (w_pos5 < w_pad + w_nsig) begin
                w_byte = {tsvn_pkg::CH_DIGIT_HI, w_digits[w_didx]};
            end else begin
                w_byte = tsvn_pkg::CH_TAB;
            end
        end else begin
            w_byte = i_job.tail[w_tidx_full[tsvn_pkg::TAIL_IW-1:0]];
        end
        w_is_last = (w_pos5 == w_last_pos);
    end

    assign w_step     = i_q_valid && (!r_valid || i_m_tready);
    assign o_pop      = w_step && w_is_last;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (w_step) begin
                r_valid <= 1'b1;
                r_pos   <= w_is_last ? '0 : r_pos + 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_byte <= w_byte;
            r_last <= w_is_last;
        end
    end

endmodule

// ===== src/text_stream_visualizer_numberer.sv =====
// ----------------------------------------------------------------------------
// text_stream_visualizer_numberer: line numbering and visible-character filter
// Byte stream in, expanded byte stream out, with an APB register file.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one text byte per word on s_tdata; s_tuser marks the first
//   byte of a file and restarts the line count, squeeze mark and line start.
//   Master stream: one output byte per word on m_tdata; m_tlast flags the
//   final word caused by an input word. A squeezed blank line yields none.
//   Config: six one-bit flags at byte addresses 0, 4, .. 20; write them only
//   while the block is idle. pready is tied high, prdata reads back a flag.
// Timing:
//   An accepted input word is written into the job queue; the expander then
//   renders its output words into the registered output stage.
//   The expander emits one word per cycle while m_tready is high, so plain bytes
//   stream at one word per cycle in both directions; an input word that expands
//   to N words (line number, escapes, up to 15 words) holds the expander until
//   its last word, and the two-entry job queue then fills and drops s_tready.
// Reset: synchronous, active low; clears flags, empties queue and output,
//   sets line start, clears the count. No clearing pass is needed.
// Stall: when m_tready is low the output word holds, the expander waits,
//   and the front keeps accepting until the job queue is full.
// ----------------------------------------------------------------------------
module text_stream_visualizer_numberer #(
    parameter int NUMBER_FIELD_WIDTH = tsvn_pkg::NUMBER_FIELD_WIDTH_DEF,
    parameter int COUNT_DIGITS       = tsvn_pkg::COUNT_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tsvn_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
    input  logic                          s_tuser,   // [0] first_of_file
    // Master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsvn_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsvn_pkg::PADDR_W-1:0]  paddr,
    input  logic [tsvn_pkg::PDATA_W-1:0]  pwdata,
    output logic [tsvn_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    tsvn_pkg::t_cfg w_cfg;
    tsvn_pkg::t_job w_push_job, w_head_job;
    logic           w_push, w_pop, w_q_full, w_q_valid;

    // Mode flags
    tsvn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Classify each accepted byte and advance the line state
    tsvn_front #(
        .COUNT_DIGITS       (COUNT_DIGITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // Decouple front and back so each side stalls on its own
    tsvn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_head_job)
    );

    // Expand the head job into output words
    tsvn_back #(
        .NUMBER_FIELD_WIDTH (NUMBER_FIELD_WIDTH),
        .COUNT_DIGITS       (COUNT_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_job      (w_head_job),
        .o_pop      (w_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule

// ===== src/tsvn_checker.sv =====
// ----------------------------------------------------------------------------
// tsvn_checker: port-level assertions
// Watches the top-level ports for output hold, reset, expansion rate and
// register readback.
// ----------------------------------------------------------------------------
module tsvn_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tsvn_pkg::BYTE_W-1:0]   m_tdata,
    input  logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsvn_pkg::PADDR_W-1:0]  paddr,
    input  logic [tsvn_pkg::PDATA_W-1:0]  pwdata,
    input  logic [tsvn_pkg::PDATA_W-1:0]  prdata
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // Within one expansion the next word follows at once
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an expansion");

    // A flag write reads back at the same address
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr < 5'd24)
        |=> (paddr != $past(paddr)) || (prdata[0] == $past(pwdata[0])))
        else $error("register readback mismatch");

endmodule

bind text_stream_visualizer_numberer tsvn_checker u_checker (.*);

// ===== tb/text_stream_visualizer_numberer_tb.sv =====
// ----------------------------------------------------------------------------
// text_stream_visualizer_numberer_tb: self-checking bench of the numberer
// Streams text words through the block under several flag settings and
// idling patterns. A built-in predictor works out the expanded output words,
// and a monitor checks each output word against the oldest one predicted.
// ----------------------------------------------------------------------------
module text_stream_visualizer_numberer_tb;

    localparam int FIELD_W       = tsvn_pkg::NUMBER_FIELD_WIDTH_DEF;
    localparam int RESET_CYCLES  = 12;
    // Let in-flight words (a squeezed newline leaves no trace) clear the pipe
    localparam int DRAIN_CYCLES  = 8;
    // Cycles with no handshake on either stream before the run is abandoned
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 32;
    localparam logic [7:0] CTRL_TO_CARET = 8'h40;
    localparam logic [7:0] HIGH_BIT      = 8'h80;
    localparam logic [7:0] LOW_SEVEN     = 8'h7F;
    localparam logic [7:0] CH_HIGH_NL    = 8'h8A;

    typedef struct packed {
        logic [7:0] text;
        logic       first;
    } t_text_word;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_word;

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tsvn_pkg::BYTE_W-1:0]    s_tdata  = '0;   // [7:0] in_byte
    logic                           s_tuser  = 1'b0; // [0] first_of_file
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tsvn_pkg::BYTE_W-1:0]    m_tdata;         // [7:0] out_byte
    logic                           m_tlast;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [tsvn_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [tsvn_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [tsvn_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Text words waiting for the driver, output words waiting for the block
    t_text_word pending_text[$];
    t_out_word  expected_words[$];

    // Shadow of the flags and of the line state
    tsvn_pkg::t_cfg flags_mirror  = '0;
    logic           at_line_start = 1'b1;
    logic           blank_seen    = 1'b0;
    logic [31:0]    line_no       = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    text_stream_visualizer_numberer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    // Work out the output words of one accepted text word and queue them
    task automatic render_text_word(input logic [7:0] text, input logic first);
        logic [7:0]  ch;
        logic [7:0]  out_bytes[$];
        logic [7:0]  digits[$];
        logic [31:0] v;
        int          k;
        ch = text;
        if (first) begin
            line_no       = '0;
            blank_seen    = 1'b0;
            at_line_start = 1'b1;
        end
        if (at_line_start) begin
            if (flags_mirror.squeeze_blank) begin
                if (ch == tsvn_pkg::CH_NL) begin
                    // Drop a blank line after a blank line; line start holds
                    if (blank_seen) return;
                    blank_seen = 1'b1;
                end else begin
                    blank_seen = 1'b0;
                end
            end
            if (flags_mirror.number_lines) begin
                if (!flags_mirror.number_nonblank_only || ch != tsvn_pkg::CH_NL) begin
                    line_no = line_no + 32'd1;   // wraps past 2^32 - 1
                    v = line_no;
                    do begin
                        digits.push_front({tsvn_pkg::CH_DIGIT_HI, 4'(v % 10)});
                        v = v / 10;
                    end while (v != 0);
                    for (k = digits.size(); k < FIELD_W; k++)
                        out_bytes.push_back(tsvn_pkg::CH_SPACE);
                    foreach (digits[d]) out_bytes.push_back(digits[d]);
                    out_bytes.push_back(tsvn_pkg::CH_TAB);
                end else if (flags_mirror.mark_line_ends) begin
                    // Uncounted blank line: pad the number field
                    for (k = 0; k < FIELD_W; k++) out_bytes.push_back(tsvn_pkg::CH_SPACE);
                    out_bytes.push_back(tsvn_pkg::CH_TAB);
                end
            end
        end
        if (ch == tsvn_pkg::CH_NL) begin
            if (flags_mirror.mark_line_ends) out_bytes.push_back(tsvn_pkg::CH_DOLLAR);
            out_bytes.push_back(ch);
        end else if (ch == tsvn_pkg::CH_TAB && flags_mirror.show_tabs) begin
            out_bytes.push_back(tsvn_pkg::CH_CARET);
            out_bytes.push_back(tsvn_pkg::CH_I);
        end else if (ch != tsvn_pkg::CH_TAB && flags_mirror.show_nonprinting) begin
            if ((ch & HIGH_BIT) != 0) begin
                out_bytes.push_back(tsvn_pkg::CH_M);
                out_bytes.push_back(tsvn_pkg::CH_DASH);
                ch = ch & LOW_SEVEN;
            end
            if (ch < tsvn_pkg::CH_SPACE || ch == tsvn_pkg::CH_DEL) begin
                out_bytes.push_back(tsvn_pkg::CH_CARET);
                out_bytes.push_back(ch == tsvn_pkg::CH_DEL ? tsvn_pkg::CH_QMARK :
                                    (ch | CTRL_TO_CARET));
            end else begin
                out_bytes.push_back(ch);
            end
        end else begin
            out_bytes.push_back(ch);
        end
        // A high newline shown as M-^J also ends the line
        at_line_start = (ch == tsvn_pkg::CH_NL);
        if (out_bytes.size() > tsvn_pkg::MAX_RES)
            out_bytes = out_bytes[0:tsvn_pkg::MAX_RES-1];
        foreach (out_bytes[j])
            expected_words.push_back('{data: out_bytes[j], last: (j == out_bytes.size() - 1)});
    endtask

    // Write one flag register through a setup and an access cycle
    task automatic write_flag(input tsvn_pkg::t_reg_idx idx, input logic value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tsvn_pkg::PADDR_W'(4 * idx);
        // Upper bits are don't-care; only bit 0 lands in the register
        pwdata  <= {31'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tsvn_pkg::REG_NUMBER_LINES:     flags_mirror.number_lines         = value;
            tsvn_pkg::REG_NUMBER_NONBLANK:  flags_mirror.number_nonblank_only = value;
            tsvn_pkg::REG_MARK_LINE_ENDS:   flags_mirror.mark_line_ends       = value;
            tsvn_pkg::REG_SQUEEZE_BLANK:    flags_mirror.squeeze_blank        = value;
            tsvn_pkg::REG_SHOW_TABS:        flags_mirror.show_tabs            = value;
            tsvn_pkg::REG_SHOW_NONPRINTING: flags_mirror.show_nonprinting     = value;
            default: ;
        endcase
    endtask

    // Bit i of the setting goes to register i
    task automatic apply_flags(input logic [5:0] setting);
        int i;
        for (i = 0; i < 6; i++) write_flag(tsvn_pkg::t_reg_idx'(i), setting[i]);
    endtask

    // Hold until every word is accepted and every output word has arrived
    task automatic drain_block();
        do @(posedge i_clk);
        while (pending_text.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
            3:       begin send_idle_pct = 13; recv_stall_pct = 13; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic queue_text(input logic [7:0] text, input logic first);
        pending_text.push_back('{text: text, first: first});
    endtask

    // Mostly ordinary lines with frequent blank runs; some escapes and noise
    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'($urandom_range(32, 126));
        if (r < 65) return tsvn_pkg::CH_NL;
        if (r < 73) return tsvn_pkg::CH_TAB;
        if (r < 85) return 8'($urandom_range(0, 255));
        if (r < 89) return CH_HIGH_NL;
        if (r < 92) return tsvn_pkg::CH_DEL;
        if (r < 96) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(128, 255));
    endfunction

    // Driver: present queued text words, idle at random between them
    always @(posedge i_clk) begin : drive_text
        t_text_word nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) render_text_word(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (pending_text.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_text.pop_front();
                    s_tdata  <= nxt.text;
                    s_tuser  <= nxt.first;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted output word, stall at random
    always @(posedge i_clk) begin : check_output
        t_out_word want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual data %h last %b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: abandon the run when neither stream moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : run_test
        int p;
        int n;
        logic [5:0] setting;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every flag on: numbering, padding of blank lines, squeezing, escapes
        set_idling(0);
        apply_flags(6'b111111);
        queue_text("a", 1'b1);
        queue_text(tsvn_pkg::CH_NL, 1'b0);
        queue_text(tsvn_pkg::CH_NL, 1'b0);        // blank line, padded number field
        queue_text(tsvn_pkg::CH_NL, 1'b0);        // squeezed, no output
        queue_text(tsvn_pkg::CH_TAB, 1'b0);
        queue_text(8'h00, 1'b0);
        queue_text(tsvn_pkg::CH_DEL, 1'b0);
        queue_text(8'hFF, 1'b0);
        queue_text(CH_HIGH_NL, 1'b0);             // M-^J, then a new line starts
        queue_text("b", 1'b0);
        queue_text(HIGH_BIT, 1'b0);
        queue_text(8'h1F, 1'b0);
        queue_text(tsvn_pkg::CH_SPACE, 1'b0);
        queue_text(8'h7E, 1'b0);
        queue_text(tsvn_pkg::CH_NL, 1'b0);
        queue_text(tsvn_pkg::CH_NL, 1'b1);        // new file restarts count and squeeze mark
        queue_text("c", 1'b0);
        drain_block();

        // Nonblank numbering without end marks; tabs pass under visible mode
        apply_flags(6'b100011);
        queue_text(tsvn_pkg::CH_TAB, 1'b0);
        queue_text(tsvn_pkg::CH_NL, 1'b0);
        queue_text(tsvn_pkg::CH_NL, 1'b0);
        queue_text(8'hC1, 1'b0);
        queue_text(tsvn_pkg::CH_NL, 1'b0);
        drain_block();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) setting = 6'b000000;
            else if (p == RANDOM_PHASES - 1) setting = 6'b111111;
            else setting = 6'($urandom());
            apply_flags(setting);
            set_idling(p % 4);
            for (n = 0; n < PHASE_WORDS; n++)
                queue_text(random_text_byte(), $urandom_range(0, 99) < 3);
            drain_block();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
